[rtl/ctda_pkg.sv]
`timescale 1ns / 1ps
// ctda_pkg: shared types, constants and the output saturation function
// for the code table distance accumulator. No dependencies.

package ctda_pkg;

    // geometry
    localparam int LANES         = 8;
    localparam int LANE_W        = $clog2(LANES);
    localparam int TABLE_ENTRIES = 256;
    localparam int CODE_W        = $clog2(TABLE_ENTRIES);
    localparam int VALUE_W       = 32;
    localparam int LEVEL_W       = 4;
    localparam int LEVEL_RESET   = 8;
    // running sum: input plus one table value per lane, never overflows
    localparam int SUM_W         = VALUE_W + LANE_W + 1;

    // operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_ACCUM = 1'b1;

    // one request as it moves down the cell chain
    typedef struct packed {
        logic                          valid;
        logic                          op;
        logic [LANE_W-1:0]             lane;
        logic [SUM_W-1:0]              sum;
        logic [LANES-1:0][CODE_W-1:0]  code;
        logic                          last;
        logic [LEVEL_W-1:0]            lanes;
    } item_t;

    // clamp the wide running sum to the signed distance range
    function automatic logic [VALUE_W-1:0] sat_distance(input logic [SUM_W-1:0] sum);
        logic signed [SUM_W-1:0] s;
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        s  = signed'(sum);
        hi = SUM_W'({1'b0, {(VALUE_W-1){1'b1}}});
        lo = -hi - SUM_W'(1);
        if (s > hi) begin
            return {1'b0, {(VALUE_W-1){1'b1}}};
        end
        else if (s < lo) begin
            return {1'b1, {(VALUE_W-1){1'b0}}};
        end
        else begin
            return s[VALUE_W-1:0];
        end
    endfunction

endpackage

[rtl/code_table_distance_accumulate.sv]
`timescale 1ns / 1ps
// code_table_distance_accumulate: top level, entry logic, chain of eight
// lane cells and the saturating output register. Uses ctda_pkg, ctda_cell.
//
//  channel | handshake             | payload
//  --------+-----------------------+----------------------------------------
//  in      | in_valid / in_stall   | operation table_lane value code_0..7
//          |                       | last_point
//  out     | out_valid / out_stall | distance last_out
//  cfg     | cfg_valid / cfg_ready | cfg_data (level width)
//
// One request per cycle while the chain is not frozen; a request is
// registered in the first lane cell when accepted, then in each further
// cell in turn, each with a registered table read, and an accumulate's
// result then in the output register. Table writes ride the same chain,
// so they stay in order with accumulates, and produce no result.
// The chain freezes only while a result waits at a stalled output and the
// last cell holds another accumulate. No clearing pass: tables are
// undefined until written. Reset sets level width to 8.

module code_table_distance_accumulate (
    input  logic                                clk,
    input  logic                                rst_n,
    // input requests
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                operation,
    input  logic [ctda_pkg::LANE_W-1:0]         table_lane,
    input  logic signed [ctda_pkg::VALUE_W-1:0] value,
    input  logic [ctda_pkg::CODE_W-1:0]         code_0,
    input  logic [ctda_pkg::CODE_W-1:0]         code_1,
    input  logic [ctda_pkg::CODE_W-1:0]         code_2,
    input  logic [ctda_pkg::CODE_W-1:0]         code_3,
    input  logic [ctda_pkg::CODE_W-1:0]         code_4,
    input  logic [ctda_pkg::CODE_W-1:0]         code_5,
    input  logic [ctda_pkg::CODE_W-1:0]         code_6,
    input  logic [ctda_pkg::CODE_W-1:0]         code_7,
    input  logic                                last_point,
    // results
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [ctda_pkg::VALUE_W-1:0] distance,
    output logic                                last_out,
    // configuration
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ctda_pkg::LEVEL_W-1:0]        cfg_data
);
    import ctda_pkg::*;

    logic [LEVEL_W-1:0]  level_width_reg;
    logic [LEVEL_W-1:0]  lanes_used;
    item_t               chain [LANES+1];
    item_t               tail;
    logic                tail_acc;
    logic                adv;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [VALUE_W-1:0]  distance_reg;
    logic [VALUE_W-1:0]  distance_next;
    logic                last_reg;
    logic                last_next;
    logic                load_out;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_width_reg <= LEVEL_W'(LEVEL_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            level_width_reg <= cfg_data;
        end
    end

    // lanes beyond the chain are not summed
    assign lanes_used = (level_width_reg > LEVEL_W'(LANES)) ? LEVEL_W'(LANES)
                                                            : level_width_reg;

    // entry request into the first cell
    always_comb
    begin
        chain[0].valid   = in_valid;
        chain[0].op      = operation;
        chain[0].lane    = table_lane;
        chain[0].sum     = {{(SUM_W-VALUE_W){value[VALUE_W-1]}}, value};
        chain[0].code[0] = code_0;
        chain[0].code[1] = code_1;
        chain[0].code[2] = code_2;
        chain[0].code[3] = code_3;
        chain[0].code[4] = code_4;
        chain[0].code[5] = code_5;
        chain[0].code[6] = code_6;
        chain[0].code[7] = code_7;
        chain[0].last    = last_point;
        chain[0].lanes   = lanes_used;
    end

    // chain of lane cells
    for (genvar g = 0; g < LANES; g++)
    begin : g_cell
        ctda_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .adv        (adv),
            .cell_index (LANE_W'(g)),
            .in_item    (chain[g]),
            .out_item   (chain[g+1])
        );
    end

    // chain advance: blocked only by an accumulate meeting a held result
    assign tail     = chain[LANES];
    assign tail_acc = tail.valid && (tail.op == OP_ACCUM);
    assign adv      = !(out_valid_reg && out_stall && tail_acc);
    assign in_stall = !adv;
    assign load_out = adv && tail_acc;

    // output register next values
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        distance_next  = distance_reg;
        last_next      = last_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            distance_next  = sat_distance(tail.sum);
            last_next      = tail.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        distance_reg <= distance_next;
        last_reg     <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign distance  = signed'(distance_reg);
    assign last_out  = last_reg;

`ifndef SYNTH
    // an accumulate leaving the chain always shows up as a result
    a_tail_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid)
        else $error("accumulate left the chain without a result");
    // a waiting result does not block writes or bubbles behind it
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall && !tail_acc) |-> !in_stall)
        else $error("input stalled with no accumulate at the chain tail");
    // positive overflow clamps to the largest distance
    a_sat_high: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && !tail.sum[SUM_W-1] && (tail.sum[SUM_W-2:VALUE_W-1] != '0))
        |=> (distance_reg == {1'b0, {(VALUE_W-1){1'b1}}}))
        else $error("positive overflow not saturated");
`endif

endmodule

[rtl/ctda_cell.sv]
`timescale 1ns / 1ps
// ctda_cell: one lane of the chain, holding that lane's lookup table,
// applying table writes and adding the looked-up value. Uses ctda_pkg.

module ctda_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic [ctda_pkg::LANE_W-1:0]  cell_index,
    input  ctda_pkg::item_t              in_item,
    output ctda_pkg::item_t              out_item
);
    import ctda_pkg::*;

    logic [VALUE_W-1:0] table_mem [TABLE_ENTRIES];
    logic [VALUE_W-1:0] rd_data_reg;
    item_t              item_reg;
    logic               wr_en;
    logic               lane_on;

    // stage register, moves with the whole chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
        end
        else if (adv)
        begin
            item_reg <= in_item;
        end
    end

    // table write for this lane, read at this lane's code byte
    assign wr_en = adv && in_item.valid && (in_item.op == OP_WRITE)
                   && (in_item.lane == cell_index);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[in_item.code[0]] <= in_item.sum[VALUE_W-1:0];
        end
        if (adv)
        begin
            rd_data_reg <= table_mem[in_item.code[cell_index]];
        end
    end

    // add the table value when this lane is enabled
    assign lane_on = item_reg.valid && (item_reg.op == OP_ACCUM)
                     && (LEVEL_W'(cell_index) < item_reg.lanes);

    always_comb
    begin
        out_item = item_reg;
        if (lane_on)
        begin
            out_item.sum = item_reg.sum
                         + {{(SUM_W-VALUE_W){rd_data_reg[VALUE_W-1]}}, rd_data_reg};
        end
    end

`ifndef SYNTH
    // a frozen chain keeps both the stage and the table read
    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(item_reg))
        else $error("cell stage changed while chain frozen");
    a_hold_read: assert property (@(posedge clk) disable iff (!rst_n)
        (!adv && !$past(wr_en)) |=> (rd_data_reg === $past(rd_data_reg)))
        else $error("table read data changed while chain frozen");
    // writes and bubbles pass through the cell untouched
    a_write_passes: assert property (@(posedge clk) disable iff (!rst_n)
        !(item_reg.valid && (item_reg.op == OP_ACCUM)) |-> (out_item == item_reg))
        else $error("cell changed a request that is not an accumulate");
`endif

endmodule
